// File: hw/rtl/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Free slots needed before a request is taken: one full group of bytes.
  localparam int unsigned MAX_RES = 3;

  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t map_char(input logic [7:0] c);
    sextet_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
      r = '{valid: 1'b1, value: d[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h61;
      r = '{valid: 1'b1, value: d[5:0] + SEXTET_LOWER};
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      r = '{valid: 1'b1, value: d[5:0] + SEXTET_DIGIT};
    end else if (c == 8'h2B) begin
      r = '{valid: 1'b1, value: SEXTET_PLUS};
    end else if (c == 8'h2F) begin
      r = '{valid: 1'b1, value: SEXTET_SLASH};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/base64_stream_decoder.sv
`default_nettype none

// Channel   Direction  tdata          tuser     tlast
// s_axis    in         char_in[7:0]   -         stream_end
// m_axis    out        byte_out[7:0]  has_byte  last_out
//
// A request is decoded in the cycle it is taken and its results enter an
// eight-entry result queue, so one request per cycle is accepted while three entries are free.
// Results leave the queue one per cycle while m_axis_tready is high.
// s_axis_tready is high while at least three queue entries are free.
// A synchronous reset empties the queue and the sextet count.
// A stalled m_axis holds its head result until it is taken.
module base64_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // char_in[7:0]
  input  wire logic       s_axis_tlast,   // stream_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // byte_out[7:0]
  output logic            m_axis_tuser,   // has_byte
  output logic            m_axis_tlast    // last_out
);
  import b64d_pkg::*;

  logic [5:0]     store [4];
  logic [1:0]     count;
  logic [1:0]     count_next;

  res_t           queue [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QCW-1:0] fill;

  sextet_t        sx;
  logic [5:0]     st [4];
  logic [2:0]     held;
  logic           full_group;
  logic [7:0]     b0;
  logic [7:0]     b1;
  logic [7:0]     b2;
  res_t           res [MAX_RES];
  logic [1:0]     n;
  logic           s_acc;
  logic           m_acc;

  assign s_axis_tready = (fill <= QCW'(QDEPTH - MAX_RES));
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fill != '0);
  assign m_acc         = m_axis_tvalid && m_axis_tready;

  assign m_axis_tdata = queue[rp].data;
  assign m_axis_tuser = queue[rp].has_byte;
  assign m_axis_tlast = queue[rp].last;

  always_comb begin
    sx = map_char(s_axis_tdata);
    for (int i = 0; i < 4; i++) begin
      st[i] = (sx.valid && (count == 2'(i))) ? sx.value : store[i];
    end
    full_group = sx.valid && (count == 2'd3);
    held       = sx.valid ? ({1'b0, count} + 3'd1) : {1'b0, count};
    b0 = {st[0], st[1][5:4]};
    b1 = {st[1][3:0], st[2][5:2]};
    b2 = {st[2][1:0], st[3]};

    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '0;
    end
    n = 2'd0;
    if (full_group) begin
      res[0] = '{data: b0, has_byte: 1'b1, last: 1'b0};
      res[1] = '{data: b1, has_byte: 1'b1, last: 1'b0};
      res[2] = '{data: b2, has_byte: 1'b1, last: s_axis_tlast};
      n      = 2'd3;
    end else if (s_axis_tlast) begin
      if (held >= 3'd2) begin
        res[0] = '{data: b0, has_byte: 1'b1, last: (held == 3'd2)};
        n      = 2'd1;
        if (held == 3'd3) begin
          res[1] = '{data: b1, has_byte: 1'b1, last: 1'b1};
          n      = 2'd2;
        end
      end else begin
        res[0] = '{data: 8'h00, has_byte: 1'b0, last: 1'b1};
        n      = 2'd1;
      end
    end

    // A full group wraps the count to zero; the end of a stream clears it.
    count_next = s_axis_tlast ? 2'd0 : held[1:0];
  end

  always_ff @(posedge clk) begin
    if (s_acc && sx.valid) begin
      store[count] <= sx.value;
    end
    if (s_acc) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (2'(k) < n) begin
          queue[wp + QAW'(k)] <= res[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wp    <= '0;
      rp    <= '0;
      fill  <= '0;
    end else begin
      if (s_acc) begin
        count <= count_next;
        wp    <= wp + QAW'(n);
      end
      if (m_acc) begin
        rp <= rp + QAW'(1);
      end
      fill <= fill + (s_acc ? QCW'(n) : QCW'(0)) - (m_acc ? QCW'(1) : QCW'(0));
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCW'(QDEPTH))
    else $error("result queue overflow");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (fill <= QCW'(QDEPTH - MAX_RES)))
    else $error("request taken without room for a full group");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_axis_tlast) |=> m_axis_tvalid)
    else $error("end of stream produced no result");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_axis_tlast) |=> (count == 2'd0))
    else $error("sextet count not cleared at end of stream");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("results pending after reset");

endmodule

`default_nettype wire
